// ===== sv/mlm_pkg.sv =====
package mlm_pkg;

  // Bus access kinds carried in the mode field of an input beat.
  typedef enum logic [1:0] {
    MODE_READ       = 2'd0,
    MODE_WRITE      = 2'd1,
    MODE_SOFT_RESET = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  // Where the data of a read access comes from.
  typedef enum logic [1:0] {
    SRC_NONE    = 2'd0,
    SRC_SCRATCH = 2'd1,
    SRC_OPEN    = 2'd2,
    SRC_ROM     = 2'd3
  } read_src_t;

  localparam int unsigned SCRATCH_DEPTH = 4;
  localparam int unsigned SCRATCH_IDX_W = $clog2(SCRATCH_DEPTH);
  localparam int unsigned SCRATCH_W     = 4;
  localparam int unsigned PRG_OUT_W     = 6;
  localparam int unsigned CHR_W         = 7;

  // Address decode constants.
  localparam logic [3:0] EXP_PAGE      = 4'h5;  // $5000-$5FFF
  localparam logic [4:0] SCRATCH_PAGE  = 5'h0B; // $5800-$5FFF, address[15:11]
  localparam int unsigned SCRATCH_SEL_BIT = 11;
  localparam int unsigned ROM_SEL_BIT  = 15;
  localparam int unsigned LOCK_BIT     = 8;
  localparam int unsigned PRG16_BIT    = 7;
  localparam int unsigned DIP_EN_BIT   = 6;
  localparam int unsigned MIRROR_BIT   = 7;

  // One decoded bus access, as seen by the banking logic.
  typedef struct packed {
    logic        latch_wr;
    logic        soft_rst;
    logic [15:0] address;
    logic [7:0]  data;
  } bank_cmd_t;

  // Banking state after the current access has been applied.
  typedef struct packed {
    logic [PRG_OUT_W-1:0] prg_low;
    logic [PRG_OUT_W-1:0] prg_high;
    logic [CHR_W-1:0]     chr_bank;
    logic                 horiz_mirror;
    logic                 locked;
    logic                 dip_en;
  } bank_view_t;

endpackage

// ===== sv/mlm_if.sv =====
interface mlm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, mode, address, write_data, input ready);
  modport sink   (input valid, mode, address, write_data, output ready);
endinterface

interface mlm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  read_source;
  logic [3:0]  read_data;
  logic [15:0] rom_read_address;
  logic [5:0]  prg_bank_low;
  logic [5:0]  prg_bank_high;
  logic [6:0]  chr_bank;
  logic        mirror_horizontal;
  logic        locked;

  modport source (output valid, read_source, read_data, rom_read_address, prg_bank_low,
                  prg_bank_high, chr_bank, mirror_horizontal, locked, input ready);
  modport sink   (input valid, read_source, read_data, rom_read_address, prg_bank_low,
                  prg_bank_high, chr_bank, mirror_horizontal, locked, output ready);
endinterface

interface mlm_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] dip_value;

  modport source (output valid, dip_value, input ready);
  modport sink   (input valid, dip_value, output ready);
endinterface

// ===== sv/mlm_bank.sv =====
module mlm_bank #(
  parameter int unsigned PRG_BANK_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mlm_pkg::bank_cmd_t    cmd,
  output mlm_pkg::bank_view_t   view
);

  logic [PRG_BANK_BITS-1:0] bank_lo_r, bank_lo_nxt;
  logic [PRG_BANK_BITS-1:0] bank_hi_r, bank_hi_nxt;
  logic [4:0]               chr_up_r, chr_up_nxt;
  logic [1:0]               data_lo_r, data_lo_nxt;
  logic                     lock_r, lock_nxt;
  logic                     mirror_r, mirror_nxt;
  logic                     dip_en_r, dip_en_nxt;
  logic [PRG_BANK_BITS-1:0] sel_bank;

  assign sel_bank = cmd.address[PRG_BANK_BITS-1:0];

  always_comb begin
    bank_lo_nxt = bank_lo_r;
    bank_hi_nxt = bank_hi_r;
    chr_up_nxt  = chr_up_r;
    data_lo_nxt = data_lo_r;
    lock_nxt    = lock_r;
    mirror_nxt  = mirror_r;
    dip_en_nxt  = dip_en_r;
    if (cmd.soft_rst) begin
      bank_lo_nxt = '0;
      bank_hi_nxt = PRG_BANK_BITS'(1);
      chr_up_nxt  = '0;
      data_lo_nxt = '0;
      lock_nxt    = 1'b0;
      mirror_nxt  = 1'b0;
      dip_en_nxt  = 1'b0;
    end else if (cmd.latch_wr) begin
      // The latch itself always follows the write.
      data_lo_nxt = cmd.data[1:0];
      dip_en_nxt  = cmd.address[mlm_pkg::DIP_EN_BIT];
      if (!lock_r) begin
        lock_nxt   = cmd.address[mlm_pkg::LOCK_BIT];
        mirror_nxt = cmd.data[mlm_pkg::MIRROR_BIT];
        chr_up_nxt = cmd.data[6:2];
        if (cmd.address[mlm_pkg::PRG16_BIT]) begin
          bank_lo_nxt = sel_bank;
          bank_hi_nxt = sel_bank;
        end else begin
          bank_lo_nxt = sel_bank & ~PRG_BANK_BITS'(1);
          bank_hi_nxt = sel_bank | PRG_BANK_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_lo_r <= '0;
      bank_hi_r <= PRG_BANK_BITS'(1);
      chr_up_r  <= '0;
      data_lo_r <= '0;
      lock_r    <= 1'b0;
      mirror_r  <= 1'b0;
      dip_en_r  <= 1'b0;
    end else begin
      bank_lo_r <= bank_lo_nxt;
      bank_hi_r <= bank_hi_nxt;
      chr_up_r  <= chr_up_nxt;
      data_lo_r <= data_lo_nxt;
      lock_r    <= lock_nxt;
      mirror_r  <= mirror_nxt;
      dip_en_r  <= dip_en_nxt;
    end
  end

  logic [7:0] bank_lo_ext;
  logic [7:0] bank_hi_ext;

  assign bank_lo_ext = 8'(bank_lo_nxt);
  assign bank_hi_ext = 8'(bank_hi_nxt);

  // The view reflects the state after this access; dip_en is the value in
  // force before it, which is what a read sees (reads never change it).
  always_comb begin
    view.prg_low      = bank_lo_ext[mlm_pkg::PRG_OUT_W-1:0];
    view.prg_high     = bank_hi_ext[mlm_pkg::PRG_OUT_W-1:0];
    view.chr_bank     = {chr_up_nxt, data_lo_nxt};
    view.horiz_mirror = mirror_nxt;
    view.locked       = lock_nxt;
    view.dip_en       = dip_en_r;
  end

endmodule

// ===== sv/mlm_scratch.sv =====
module mlm_scratch (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [mlm_pkg::SCRATCH_IDX_W-1:0] idx,
  input  logic [mlm_pkg::SCRATCH_W-1:0]     wdata,
  output logic [mlm_pkg::SCRATCH_W-1:0]     rdata
);

  logic [mlm_pkg::SCRATCH_W-1:0] regs_r [mlm_pkg::SCRATCH_DEPTH];

  // Only a hard reset clears the scratch registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mlm_pkg::SCRATCH_DEPTH; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr_en) begin
      regs_r[idx] <= wdata;
    end
  end

  assign rdata = regs_r[idx];

endmodule

// ===== sv/multicart_address_latch_mapper_top.sv =====
// Multicart address-latch mapper. Each input beat is one CPU bus access
// (read, write or soft reset) and produces exactly one result beat that
// carries the read decode (scratch register, open bus or program ROM, with
// the DIP value substituted into the low ROM address nibble when latched
// address bit 6 is set) together with the banking state in force after the
// access. The block takes one beat per clock: the decode and banking update
// are a single level of logic feeding one output register, so the result of
// an access is presented in the cycle after it is accepted, and a new access is
// accepted in that same cycle whenever the output register is empty or being
// drained. The DIP value is written through the configuration channel, which
// is always ready. rst_n is a hard reset and also clears the scratch
// registers; a soft reset access clears only the latch, lock and banking.
module multicart_address_latch_mapper_top #(
  parameter int unsigned PRG_BANK_BITS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  mlm_in_if.sink        in_bus,
  mlm_out_if.source     out_bus,
  mlm_cfg_if.sink       cfg_bus
);

  // Configuration: the DIP switch value.
  logic [3:0] dip_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_r <= '0;
    end else if (cfg_bus.valid) begin
      dip_r <= cfg_bus.dip_value;
    end
  end

  // Input handshake. The output register is refilled in the same cycle it
  // drains, so the block keeps one access per clock under no back-pressure.
  logic out_valid_r;
  logic accept;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  // Address decode of the current access.
  mlm_pkg::mode_t mode;
  logic           is_write;
  logic           exp_hit;
  logic           scratch_hit;
  logic           rom_hit;

  assign mode        = mlm_pkg::mode_t'(in_bus.mode);
  assign is_write    = accept && (mode == mlm_pkg::MODE_WRITE);
  assign exp_hit     = in_bus.address[15:12] == mlm_pkg::EXP_PAGE;
  assign scratch_hit = in_bus.address[15:11] == mlm_pkg::SCRATCH_PAGE;
  assign rom_hit     = in_bus.address[mlm_pkg::ROM_SEL_BIT];

  mlm_pkg::bank_cmd_t  cmd;
  mlm_pkg::bank_view_t view;

  always_comb begin
    cmd.latch_wr = is_write && rom_hit;
    cmd.soft_rst = accept && (mode == mlm_pkg::MODE_SOFT_RESET);
    cmd.address  = in_bus.address;
    cmd.data     = in_bus.write_data;
  end

  mlm_bank #(
    .PRG_BANK_BITS (PRG_BANK_BITS)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .view  (view)
  );

  logic [mlm_pkg::SCRATCH_W-1:0] scratch_rdata;

  mlm_scratch u_scratch (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (is_write && scratch_hit),
    .idx   (in_bus.address[mlm_pkg::SCRATCH_IDX_W-1:0]),
    .wdata (in_bus.write_data[mlm_pkg::SCRATCH_W-1:0]),
    .rdata (scratch_rdata)
  );

  // Read decode. Only a read access reports a source; everything else
  // reports no read with zero data and address.
  mlm_pkg::read_src_t src_nxt;
  logic [3:0]         rdata_nxt;
  logic [15:0]        raddr_nxt;

  always_comb begin
    src_nxt   = mlm_pkg::SRC_NONE;
    rdata_nxt = '0;
    raddr_nxt = '0;
    if (mode == mlm_pkg::MODE_READ) begin
      if (exp_hit) begin
        if (in_bus.address[mlm_pkg::SCRATCH_SEL_BIT]) begin
          src_nxt   = mlm_pkg::SRC_SCRATCH;
          rdata_nxt = scratch_rdata;
        end else begin
          src_nxt = mlm_pkg::SRC_OPEN;
        end
      end else if (rom_hit) begin
        src_nxt   = mlm_pkg::SRC_ROM;
        raddr_nxt = view.dip_en ? {in_bus.address[15:4], dip_r} : in_bus.address;
      end
    end
  end

  // Output register.
  mlm_pkg::read_src_t src_r;
  logic [3:0]         rdata_r;
  logic [15:0]        raddr_r;
  logic [5:0]         prg_lo_r;
  logic [5:0]         prg_hi_r;
  logic [6:0]         chr_r;
  logic               mirror_r;
  logic               locked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_r    <= src_nxt;
      rdata_r  <= rdata_nxt;
      raddr_r  <= raddr_nxt;
      prg_lo_r <= view.prg_low;
      prg_hi_r <= view.prg_high;
      chr_r    <= view.chr_bank;
      mirror_r <= view.horiz_mirror;
      locked_r <= view.locked;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.read_source       = src_r;
  assign out_bus.read_data         = rdata_r;
  assign out_bus.rom_read_address  = raddr_r;
  assign out_bus.prg_bank_low      = prg_lo_r;
  assign out_bus.prg_bank_high     = prg_hi_r;
  assign out_bus.chr_bank          = chr_r;
  assign out_bus.mirror_horizontal = mirror_r;
  assign out_bus.locked            = locked_r;

`ifndef SYNTH
  // Every accepted access leaves a result in the output register.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_bus.valid)
    else $error("accepted access produced no result beat");

  // A soft reset always unlocks and reports no read.
  a_soft_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.mode == mlm_pkg::MODE_SOFT_RESET) |=>
      (!out_bus.locked && out_bus.read_source == mlm_pkg::SRC_NONE
       && out_bus.rom_read_address == 16'h0000))
    else $error("soft reset result carries lock or read data");

  // Non-read accesses never report read data.
  a_no_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.mode != mlm_pkg::MODE_READ) |=>
      (out_bus.read_source == mlm_pkg::SRC_NONE && out_bus.read_data == 4'h0))
    else $error("non-read access reported a read source");

  // While locked, a write to the latch cannot move the PRG banks.
  a_lock_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid_r && out_bus.locked && in_bus.mode == mlm_pkg::MODE_WRITE) |=>
      ($stable(prg_lo_r) && $stable(prg_hi_r) && out_bus.locked))
    else $error("banking changed while locked");
`endif

endmodule

// ===== verif/multicart_address_latch_mapper_top_tb.sv =====
module multicart_address_latch_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // PRG bank width given to the block; the shadow below masks banks with it.
  localparam int unsigned PRG_BITS = 6;
  // Cycles without any beat on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 4000;
  // Random accesses that do something, split over six parts of the run.
  localparam int unsigned RANDOM_ACCESSES = 960;
  localparam int unsigned PART_ACCESSES = RANDOM_ACCESSES / 6;
  // The result of an access sits in one output register, so the tail wait
  // after the last result is plenty to catch a stray extra beat.
  localparam int unsigned TAIL_CYCLES = 5;

  // One result beat as the block should present it.
  typedef struct {
    mlm_pkg::read_src_t              source;
    logic [mlm_pkg::SCRATCH_W-1:0]   data;
    logic [15:0]                     rom_addr;
    logic [mlm_pkg::PRG_OUT_W-1:0]   prg_low;
    logic [mlm_pkg::PRG_OUT_W-1:0]   prg_high;
    logic [mlm_pkg::CHR_W-1:0]       chr;
    logic                            horiz_mirror;
    logic                            locked;
  } access_result_t;

  // Shadow copy of the mapper. It tracks the latch, the lock, the banking and
  // the scratch registers, and keeps the results still owed by the block in
  // the order the accesses were accepted.
  class mapper_shadow;
    logic [3:0]                     dip;
    logic [15:0]                    latch_addr;
    logic [7:0]                     latch_data;
    logic                           lock;
    logic [mlm_pkg::CHR_W-1:0]      chr_hi;
    logic [mlm_pkg::PRG_OUT_W-1:0]  bank_lo;
    logic [mlm_pkg::PRG_OUT_W-1:0]  bank_hi;
    logic                           horiz_mirror;
    logic [mlm_pkg::SCRATCH_W-1:0]  scratch [mlm_pkg::SCRATCH_DEPTH];
    access_result_t                 pending_results[$];
    int unsigned                    mismatch_count;

    function new();
      dip = '0;
      clear_banking();
      foreach (scratch[i]) scratch[i] = '0;
      mismatch_count = 0;
    endfunction

    // A soft reset only touches this part; scratch survives it.
    function void clear_banking();
      latch_addr = '0;
      latch_data = '0;
      lock = 1'b0;
      chr_hi = '0;
      bank_lo = '0;
      bank_hi = mlm_pkg::PRG_OUT_W'(1);
      horiz_mirror = 1'b0;
    endfunction

    function void apply_latch();
      logic [15:0] mask;
      logic [15:0] even;
      mask = 16'((32'd1 << PRG_BITS) - 1);
      if (lock) return;
      lock = latch_addr[mlm_pkg::LOCK_BIT];
      if (latch_addr[mlm_pkg::PRG16_BIT]) begin
        // 16K mode: the same bank shows in both windows.
        bank_lo = latch_addr[mlm_pkg::PRG_OUT_W-1:0] & mask[mlm_pkg::PRG_OUT_W-1:0];
        bank_hi = bank_lo;
      end else begin
        // 32K mode: the even bank at $8000, its odd partner at $C000.
        even = latch_addr & ~16'd1 & mask;
        bank_lo = even[mlm_pkg::PRG_OUT_W-1:0];
        bank_hi = even[mlm_pkg::PRG_OUT_W-1:0] |
                  (mask[mlm_pkg::PRG_OUT_W-1:0] & mlm_pkg::PRG_OUT_W'(1));
      end
      horiz_mirror = latch_data[mlm_pkg::MIRROR_BIT];
      chr_hi = latch_data[mlm_pkg::CHR_W-1:0] & 7'h7C;
    endfunction

    function void set_dip(logic [3:0] value);
      dip = value;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void note_access(mlm_pkg::mode_t m, logic [15:0] a, logic [7:0] d);
      access_result_t r;
      r.source = mlm_pkg::SRC_NONE;
      r.data = '0;
      r.rom_addr = '0;
      case (m)
        mlm_pkg::MODE_READ: begin
          if (a[15:12] == mlm_pkg::EXP_PAGE) begin
            if (a[mlm_pkg::SCRATCH_SEL_BIT]) begin
              r.source = mlm_pkg::SRC_SCRATCH;
              r.data = scratch[a[mlm_pkg::SCRATCH_IDX_W-1:0]];
            end else begin
              r.source = mlm_pkg::SRC_OPEN;
            end
          end else if (a[mlm_pkg::ROM_SEL_BIT]) begin
            r.source = mlm_pkg::SRC_ROM;
            r.rom_addr = latch_addr[mlm_pkg::DIP_EN_BIT] ? {a[15:4], dip} : a;
          end
        end
        mlm_pkg::MODE_WRITE: begin
          if (a[15:11] == mlm_pkg::SCRATCH_PAGE) begin
            scratch[a[mlm_pkg::SCRATCH_IDX_W-1:0]] = d[mlm_pkg::SCRATCH_W-1:0];
          end else if (a[mlm_pkg::ROM_SEL_BIT]) begin
            latch_addr = a;
            latch_data = d;
            apply_latch();
          end
        end
        mlm_pkg::MODE_SOFT_RESET: clear_banking();
        default: ;
      endcase
      r.prg_low = bank_lo;
      r.prg_high = bank_hi;
      r.chr = chr_hi | {5'd0, latch_data[1:0]};
      r.horiz_mirror = horiz_mirror;
      r.locked = lock;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_beat(access_result_t got);
      access_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no access waiting for it");
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      compare("read_source", 16'(want.source), 16'(got.source));
      compare("read_data", 16'(want.data), 16'(got.data));
      compare("rom_read_address", want.rom_addr, got.rom_addr);
      compare("prg_bank_low", 16'(want.prg_low), 16'(got.prg_low));
      compare("prg_bank_high", 16'(want.prg_high), 16'(got.prg_high));
      compare("chr_bank", 16'(want.chr), 16'(got.chr));
      compare("mirror_horizontal", 16'(want.horiz_mirror), 16'(got.horiz_mirror));
      compare("locked", 16'(want.locked), 16'(got.locked));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mlm_in_if  in_if ();
  mlm_out_if out_if ();
  mlm_cfg_if cfg_if ();

  multicart_address_latch_mapper_top #(
    .PRG_BANK_BITS(PRG_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if),
    .cfg_bus(cfg_if)
  );

  mapper_shadow shadow;

  // Chance, in percent, that the sender or the receiver sits out a cycle.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  // 8 ns clock, starting low so the first rising edge comes at 4 ns.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The receiver drops ready at random; the rate is changed between phases.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every beat is observed at the rising edge at which it is taken, before
  // any driver update of that edge lands. An accepted access is noted first,
  // so that a result can never be checked against a stale expectation.
  always @(posedge clk) begin
    access_result_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        shadow.set_dip(cfg_if.dip_value);
      end
      if (in_if.valid && in_if.ready) begin
        shadow.note_access(mlm_pkg::mode_t'(in_if.mode), in_if.address,
                           in_if.write_data);
      end
      if (out_if.valid && out_if.ready) begin
        got.source = mlm_pkg::read_src_t'(out_if.read_source);
        got.data = out_if.read_data;
        got.rom_addr = out_if.rom_read_address;
        got.prg_low = out_if.prg_bank_low;
        got.prg_high = out_if.prg_bank_high;
        got.chr = out_if.chr_bank;
        got.horiz_mirror = out_if.mirror_horizontal;
        got.locked = out_if.locked;
        shadow.check_beat(got);
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("multicart_address_latch_mapper_top test failed");
      $finish;
    end
  end

  // Present one bus access and hold it until the block takes it. Idle cycles
  // in front of the beat come from the sender's idle rate.
  task automatic send_access(input mlm_pkg::mode_t m, input logic [15:0] a,
                             input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.address <= a;
    in_if.write_data <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every access has come back as a result.
  // The first edge lets the monitor note the beat taken at the current edge.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  // DIP switch writes are only made while nothing is in flight.
  task automatic write_dip(input logic [3:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.dip_value <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Pick one random access. Most writes go to the latch with the lock bit
  // clear, so the banking keeps moving; soft resets now and then undo any
  // lock. Fully random addresses keep every address bit toggling. Returns 0
  // for an access that the block merely ignores.
  function automatic bit pick_access(output mlm_pkg::mode_t m, output logic [15:0] a,
                                     output logic [7:0] d);
    int unsigned roll;
    roll = $urandom_range(99);
    a = 16'($urandom);
    d = 8'($urandom);
    m = mlm_pkg::MODE_READ;
    if (roll < 45) begin
      case ($urandom_range(3))
        0, 1: a[mlm_pkg::ROM_SEL_BIT] = 1'b1;
        2: a[15:12] = mlm_pkg::EXP_PAGE;
        default: ;
      endcase
      return 1'b1;
    end
    if (roll < 88) begin
      m = mlm_pkg::MODE_WRITE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          a[mlm_pkg::ROM_SEL_BIT] = 1'b1;
          if ($urandom_range(7) != 0) a[mlm_pkg::LOCK_BIT] = 1'b0;
        end
        5, 6, 7: a[15:11] = mlm_pkg::SCRATCH_PAGE;
        default: ;
      endcase
      return (a[15:11] == mlm_pkg::SCRATCH_PAGE) || a[mlm_pkg::ROM_SEL_BIT];
    end
    if (roll < 95) begin
      m = mlm_pkg::MODE_SOFT_RESET;
      return 1'b1;
    end
    m = mlm_pkg::MODE_UNUSED;
    return 1'b0;
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned useful;
    mlm_pkg::mode_t m;
    logic [15:0] a;
    logic [7:0] d;
    useful = 0;
    while (useful < count) begin
      if (pick_access(m, a, d)) useful++;
      send_access(m, a, d);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = mlm_pkg::MODE_READ;
    in_if.address = '0;
    in_if.write_data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.dip_value = '0;
    send_idle_pct = 7;
    recv_idle_pct = 48;
    shadow = new();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the DIP switch at its top value.
    write_dip(4'hF);
    // Scratch registers: read before any write, write every bit, mirror
    // every four bytes, and the open-bus half of the $5xxx page.
    send_access(mlm_pkg::MODE_READ, 16'h5800, 8'h00);
    send_access(mlm_pkg::MODE_WRITE, 16'h5803, 8'hFF);
    send_access(mlm_pkg::MODE_WRITE, 16'h5FFC, 8'hA5);
    send_access(mlm_pkg::MODE_READ, 16'h5FFF, 8'h00);
    send_access(mlm_pkg::MODE_READ, 16'h5804, 8'h00);
    send_access(mlm_pkg::MODE_READ, 16'h5000, 8'h00);
    send_access(mlm_pkg::MODE_READ, 16'h57FF, 8'h00);
    // Reads and writes outside both decoded areas.
    send_access(mlm_pkg::MODE_READ, 16'h0000, 8'h00);
    send_access(mlm_pkg::MODE_READ, 16'h7FFF, 8'h00);
    send_access(mlm_pkg::MODE_WRITE, 16'h0000, 8'hFF);
    send_access(mlm_pkg::MODE_WRITE, 16'h57FF, 8'hFF);
    // ROM reads with the DIP substitution off, then on in 16K mode.
    send_access(mlm_pkg::MODE_READ, 16'h8000, 8'h00);
    send_access(mlm_pkg::MODE_WRITE, 16'h80FF, 8'hFF);
    send_access(mlm_pkg::MODE_READ, 16'hFFFF, 8'h00);
    // 32K mode with an odd address, then a write that sets the lock.
    send_access(mlm_pkg::MODE_WRITE, 16'h803F, 8'h83);
    send_access(mlm_pkg::MODE_WRITE, 16'h817E, 8'h7C);
    // Locked: only the CHR low bits and the DIP enable follow the latch.
    send_access(mlm_pkg::MODE_WRITE, 16'hFEC1, 8'h83);
    send_access(mlm_pkg::MODE_READ, 16'hC123, 8'h00);
    // The unused access code changes nothing.
    send_access(mlm_pkg::MODE_UNUSED, 16'hFFFF, 8'hFF);
    // A soft reset clears the lock but keeps the scratch registers.
    send_access(mlm_pkg::MODE_SOFT_RESET, 16'hFFFF, 8'hFF);
    send_access(mlm_pkg::MODE_READ, 16'h5803, 8'h00);
    send_access(mlm_pkg::MODE_WRITE, 16'hFFFF, 8'hFF);
    send_access(mlm_pkg::MODE_READ, 16'hFFF0, 8'h00);
    send_access(mlm_pkg::MODE_SOFT_RESET, 16'h0000, 8'h00);

    // Random part in three idling phases: a slow receiver, a slow sender,
    // then both at full rate. Each phase has two parts, and before each part
    // the sender holds off until the block has nothing left in flight, which
    // is also where the DIP value gets changed.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int part = 0; part < 2; part++) begin
        drain();
        if (part == 0) begin
          write_dip((phase == 1) ? 4'hF : 4'h0);
        end else begin
          write_dip(4'($urandom));
        end
        run_random(PART_ACCESSES);
      end
    end

    // Let every result come back, then watch a little longer for extras.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatch_count == 0) begin
      $display("multicart_address_latch_mapper_top test passed");
    end else begin
      $display("multicart_address_latch_mapper_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mlm_pkg.sv
sv/mlm_if.sv
sv/mlm_bank.sv
sv/mlm_scratch.sv
sv/multicart_address_latch_mapper_top.sv
verif/multicart_address_latch_mapper_top_tb.sv
